### hw/rtl/tsat_pkg.sv
package tsat_pkg;

    localparam int SLOT_COUNT     = 128;
    localparam int RESERVED_SLOTS = 2;
    localparam int IDX_W          = $clog2(SLOT_COUNT);
    localparam int SLOT_OUT_W     = 7;

    localparam logic [7:0]  MARKER_RSVD = 8'hFF;
    localparam logic [15:0] TAG_RSVD    = 16'hFFFF;
    localparam logic [15:0] LEN_SLOT0   = 16'h0001;
    localparam logic [15:0] LEN_RSVD    = 16'h0E00;
    localparam logic [7:0]  SLOT_NONE   = 8'hFF;

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_LOOKUP  = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISS    = 2'd1,
        ST_IGNORED = 2'd2,
        ST_BADIDX  = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] tag;
        logic [7:0]  marker;
        logic [15:0] length;
        logic [7:0]  slot_in;
    } req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [SLOT_OUT_W-1:0] slot_out;
        logic [15:0]           entry_length;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  marker;
        logic [15:0] tag;
        logic [15:0] length;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        entry_t           wdata;
    } mem_req_t;

    // Contents of an entry right after reset
    function automatic entry_t reset_entry(logic [IDX_W-1:0] idx);
        entry_t e;
        e = '0;
        if (int'(idx) < RESERVED_SLOTS)
        begin
            e.marker = MARKER_RSVD;
            e.tag    = TAG_RSVD;
            e.length = (idx == '0) ? LEN_SLOT0 : LEN_RSVD;
        end
        return e;
    endfunction

    function automatic logic [SLOT_OUT_W-1:0] to_slot_out(logic [7:0] v);
        return v[SLOT_OUT_W-1:0];
    endfunction

endpackage

### hw/rtl/tagged_slot_allocation_table_top.sv
// Channel   Handshake            Payload          Accepted when
// request   start / busy         request (req_t)  start && !busy at clk rise
// result    done (1-cycle pulse) result (rsp_t)   done high, no back-pressure
//
// Allocate and lookup scan the slot RAM one entry per cycle, first fit.
// Done follows the hit, or a miss at the last slot. Release reads the
// slot, then writes it back; rejected requests are answered from idle.
// The scan rate is set by the single RAM port and its registered read.
// Reset clears per-slot valid flops at once; unwritten slots read their
// reset contents, so no clearing pass is needed.
module tagged_slot_allocation_table_top
    import tsat_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t request,
    output logic busy,
    output logic done,
    output rsp_t result
);

    mem_req_t          mem;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [SLOT_COUNT-1:0] valid_reg;
    logic              rd_valid_reg;
    logic [IDX_W-1:0]  rd_addr_reg;
    entry_t            entry;

    tsat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (mem.we),
        .addr  (mem.addr),
        .wdata (mem.wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[mem.addr];
            if (mem.we)
            begin
                valid_reg[mem.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= mem.addr;
    end

    assign entry = rd_valid_reg ? entry_t'(ram_rdata) : reset_entry(rd_addr_reg);

    tsat_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .entry   (entry),
        .mem     (mem),
        .done    (done),
        .result  (result)
    );

endmodule

### hw/rtl/tsat_ram.sv
module tsat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### hw/rtl/tsat_ctrl.sv
module tsat_ctrl
    import tsat_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  req_t     request,
    output logic     busy,
    input  entry_t   entry,
    output mem_req_t mem,
    output logic     done,
    output rsp_t     result
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_REL  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] pend_reg, pend_next;
    req_t             req_reg, req_next;
    logic             done_reg, done_next;
    rsp_t             rsp_reg, rsp_next;
    logic             hit;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

    always_comb
    begin
        if (req_reg.req_type == REQ_ALLOC)
        begin
            hit = (entry.marker == '0);
        end
        else
        begin
            hit = (entry.marker != '0) && (entry.tag == req_reg.tag);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        req_next   = req_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        mem.we     = 1'b0;
        mem.addr   = '0;
        mem.wdata  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                    pend_next = '0;
                    case (request.req_type)
                        REQ_ALLOC, REQ_LOOKUP:
                        begin
                            // slot 0 is read now, its data arrives in S_SCAN
                            state_next = S_SCAN;
                        end
                        REQ_RELEASE:
                        begin
                            if (request.slot_in == SLOT_NONE ||
                                int'(request.slot_in) < RESERVED_SLOTS)
                            begin
                                done_next = 1'b1;
                                rsp_next  = '{ST_IGNORED, '0, '0};
                            end
                            else if (int'(request.slot_in) >= SLOT_COUNT)
                            begin
                                done_next = 1'b1;
                                rsp_next  = '{ST_BADIDX, '0, '0};
                            end
                            else
                            begin
                                mem.addr   = request.slot_in[IDX_W-1:0];
                                state_next = S_REL;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            rsp_next  = '{ST_IGNORED, '0, '0};
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // entry holds slot pend_reg; the next slot is read in parallel
                if (hit)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (req_reg.req_type == REQ_ALLOC)
                    begin
                        mem.we    = 1'b1;
                        mem.addr  = pend_reg;
                        mem.wdata = '{req_reg.marker, req_reg.tag, req_reg.length};
                        rsp_next  = '{ST_OK, to_slot_out(8'(pend_reg)), req_reg.length};
                    end
                    else
                    begin
                        rsp_next = '{ST_OK, to_slot_out(8'(pend_reg)), entry.length};
                    end
                end
                else if (pend_reg == IDX_W'(SLOT_COUNT - 1))
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{ST_MISS, '0, '0};
                    state_next = S_IDLE;
                end
                else
                begin
                    pend_next = pend_reg + 1'b1;
                    mem.addr  = pend_reg + 1'b1;
                end
            end
            S_REL:
            begin
                // marker cleared, tag and length written back as read
                mem.we     = 1'b1;
                mem.addr   = req_reg.slot_in[IDX_W-1:0];
                mem.wdata  = '{8'h00, entry.tag, entry.length};
                done_next  = 1'b1;
                rsp_next   = '{ST_OK, to_slot_out(req_reg.slot_in), '0};
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

endmodule

### sim/tagged_slot_allocation_table_top_test.sv
module tagged_slot_allocation_table_top_test;
    import tsat_pkg::*;

    localparam int RANDOM_PER_PHASE = 610;
    localparam int DIRECTED_ROWS    = 19;

    typedef struct packed {
        req_t req;
        logic fixed;
        rsp_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t request = '0;
    logic busy;
    logic done;
    rsp_t result;

    // shadow copy of the slot table
    logic [7:0]  tbl_marker [SLOT_COUNT];
    logic [15:0] tbl_tag    [SLOT_COUNT];
    logic [15:0] tbl_length [SLOT_COUNT];

    rsp_t pending_results[$];
    int   mismatch_count = 0;
    dir_row_t directed_rows [DIRECTED_ROWS];

    tagged_slot_allocation_table_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .request(request),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch on %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
        mismatch_count++;
    endtask

    function automatic void clear_table();
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            tbl_marker[i] = '0;
            tbl_tag[i]    = '0;
            tbl_length[i] = '0;
            if (i < RESERVED_SLOTS)
            begin
                tbl_marker[i] = 8'hFF;
                tbl_tag[i]    = 16'hFFFF;
                tbl_length[i] = (i == 0) ? 16'd1 : 16'h0E00;
            end
        end
    endfunction

    // applies one request to the shadow table and returns its result
    function automatic rsp_t table_response(input req_t r);
        rsp_t p;
        bit   hit;
        p = '0;
        p.status = ST_IGNORED;
        hit = 1'b0;
        case (r.req_type)
            REQ_ALLOC:
            begin
                p.status = ST_MISS;
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (!hit && tbl_marker[i] == 8'd0)
                    begin
                        hit = 1'b1;
                        tbl_marker[i] = r.marker;
                        tbl_tag[i]    = r.tag;
                        tbl_length[i] = r.length;
                        p.status       = ST_OK;
                        p.slot_out     = i[SLOT_OUT_W-1:0];
                        p.entry_length = r.length;
                    end
                end
            end
            REQ_LOOKUP:
            begin
                p.status = ST_MISS;
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (!hit && tbl_marker[i] != 8'd0 && tbl_tag[i] == r.tag)
                    begin
                        hit = 1'b1;
                        p.status       = ST_OK;
                        p.slot_out     = i[SLOT_OUT_W-1:0];
                        p.entry_length = tbl_length[i];
                    end
                end
            end
            REQ_RELEASE:
            begin
                // "none" is checked ahead of the range check
                if (r.slot_in == SLOT_NONE || int'(r.slot_in) < RESERVED_SLOTS)
                    p.status = ST_IGNORED;
                else if (int'(r.slot_in) >= SLOT_COUNT)
                    p.status = ST_BADIDX;
                else
                begin
                    tbl_marker[r.slot_in[IDX_W-1:0]] = '0;
                    p.status   = ST_OK;
                    p.slot_out = r.slot_in[SLOT_OUT_W-1:0];
                end
            end
            default: p.status = ST_IGNORED;
        endcase
        return p;
    endfunction

    // fill mode pushes toward a full table, drain mode frees slots
    function automatic req_t random_request(input bit fill_mode);
        req_t r;
        int   pick;
        int   roll;
        r.tag     = 16'($urandom);
        r.marker  = 8'($urandom);
        r.length  = 16'($urandom);
        r.slot_in = 8'($urandom);
        roll = $urandom_range(0, 7);
        if (roll < 5)
            r.tag = 16'($urandom_range(0, 23));
        else if (roll == 5)
            r.tag = 16'hFFFF;
        if ($urandom_range(0, 11) == 0)
            r.marker = 8'd0;
        else if (r.marker == 8'd0)
            r.marker = 8'd1;
        if ($urandom_range(0, 6) != 0)
            r.slot_in = 8'($urandom_range(RESERVED_SLOTS, SLOT_COUNT - 1));
        pick = $urandom_range(0, 99);
        if (fill_mode)
            r.req_type = (pick < 88) ? REQ_ALLOC : (pick < 96) ? REQ_LOOKUP :
                         (pick < 99) ? REQ_RELEASE : REQ_UNUSED;
        else
            r.req_type = (pick < 20) ? REQ_ALLOC : (pick < 50) ? REQ_LOOKUP :
                         (pick < 98) ? REQ_RELEASE : REQ_UNUSED;
        return r;
    endfunction

    // called at a rising edge; returns at the edge that accepted the item
    // (or at the end of the idle gap that follows it)
    task automatic send_item(input req_t r, input bit fixed, input rsp_t want,
                             input int idle_pct);
        rsp_t p;
        request <= r;
        start   <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        p = table_response(r);
        pending_results.push_back(fixed ? want : p);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            if ($urandom_range(0, 1) == 0)
                repeat ($urandom_range(1, 3)) @(posedge clk);
            else
                repeat ($urandom_range(4, SLOT_COUNT + 4)) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 0, int'(result));
            else
            begin
                exp_rsp = pending_results.pop_front();
                if (result.status !== exp_rsp.status)
                    report_mismatch("status", int'(exp_rsp.status), int'(result.status));
                if (result.slot_out !== exp_rsp.slot_out)
                    report_mismatch("slot_out", int'(exp_rsp.slot_out),
                                    int'(result.slot_out));
                if (result.entry_length !== exp_rsp.entry_length)
                    report_mismatch("entry_length", int'(exp_rsp.entry_length),
                                    int'(result.entry_length));
            end
        end
    end

    initial
    begin
        int  idle_pct;
        int  mode_left;
        bit  fill_mode;
        directed_rows = '{
            '{'{REQ_LOOKUP,  16'hFFFF, 8'h00, 16'h0000, 8'h00}, 1'b1, '{ST_OK,      7'd0, 16'd1}},
            '{'{REQ_LOOKUP,  16'h0000, 8'h00, 16'h0000, 8'h00}, 1'b1, '{ST_MISS,    7'd0, 16'd0}},
            '{'{REQ_ALLOC,   16'h0000, 8'hFF, 16'hFFFF, 8'hFF}, 1'b1, '{ST_OK,      7'd2, 16'hFFFF}},
            '{'{REQ_ALLOC,   16'hFFFF, 8'h01, 16'h0000, 8'h00}, 1'b1, '{ST_OK,      7'd3, 16'd0}},
            '{'{REQ_ALLOC,   16'h1234, 8'h00, 16'h5555, 8'h00}, 1'b1, '{ST_OK,      7'd4, 16'h5555}},
            '{'{REQ_ALLOC,   16'hAAAA, 8'h80, 16'h00FF, 8'h00}, 1'b1, '{ST_OK,      7'd4, 16'h00FF}},
            '{'{REQ_LOOKUP,  16'h1234, 8'h00, 16'h0000, 8'h00}, 1'b0, '0},
            '{'{REQ_LOOKUP,  16'hAAAA, 8'hFF, 16'hFFFF, 8'hFF}, 1'b0, '0},
            '{'{REQ_LOOKUP,  16'h0000, 8'h00, 16'h0000, 8'h00}, 1'b0, '0},
            '{'{REQ_RELEASE, 16'h0000, 8'h00, 16'h0000, 8'hFF}, 1'b1, '{ST_IGNORED, 7'd0, 16'd0}},
            '{'{REQ_RELEASE, 16'h0000, 8'h00, 16'h0000, 8'h00}, 1'b1, '{ST_IGNORED, 7'd0, 16'd0}},
            '{'{REQ_RELEASE, 16'hFFFF, 8'hFF, 16'hFFFF, 8'h01}, 1'b1, '{ST_IGNORED, 7'd0, 16'd0}},
            '{'{REQ_RELEASE, 16'h0000, 8'h00, 16'h0000, 8'h80}, 1'b1, '{ST_BADIDX,  7'd0, 16'd0}},
            '{'{REQ_RELEASE, 16'h0000, 8'h00, 16'h0000, 8'hFE}, 1'b1, '{ST_BADIDX,  7'd0, 16'd0}},
            '{'{REQ_RELEASE, 16'h0000, 8'h00, 16'h0000, 8'h7F}, 1'b1, '{ST_OK,      7'd127, 16'd0}},
            '{'{REQ_RELEASE, 16'h0000, 8'h00, 16'h0000, 8'h02}, 1'b1, '{ST_OK,      7'd2, 16'd0}},
            '{'{REQ_LOOKUP,  16'h0000, 8'h00, 16'h0000, 8'h00}, 1'b0, '0},
            '{'{REQ_UNUSED,  16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF}, 1'b1, '{ST_IGNORED, 7'd0, 16'd0}},
            '{'{REQ_ALLOC,   16'h5A5A, 8'h7F, 16'h8000, 8'h00}, 1'b0, '0}
        };
        clear_table();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].want, 0);

        fill_mode = 1'b1;
        mode_left = $urandom_range(150, 250);
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 37 : (ph == 1) ? 45 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (mode_left == 0)
                begin
                    fill_mode = !fill_mode;
                    mode_left = fill_mode ? $urandom_range(150, 250) : $urandom_range(80, 160);
                end
                mode_left--;
                send_item(random_request(fill_mode), 1'b0, '0, idle_pct);
            end
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SLOT_COUNT + 8) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("missing results", 0, pending_results.size());

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/tsat_pkg.sv
hw/rtl/tsat_ram.sv
hw/rtl/tsat_ctrl.sv
hw/rtl/tagged_slot_allocation_table_top.sv
sim/tagged_slot_allocation_table_top_test.sv
